/* rtl/hrrn_pkg.sv */
package hrrn_pkg;

   // batch size and derived index widths
   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   // field widths
   localparam int DATA_W  = 16;
   localparam int JOB_W   = 7;
   localparam int TIME_W  = 21;
   localparam int TOTAL_W = 27;
   localparam int SUM_W   = TOTAL_W + 1;
   localparam int NUM_W   = TIME_W + 1;            // wait + burst
   localparam int PROD_W  = NUM_W + DATA_W;        // cross product

   localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN_INIT,
      OP_READ,
      OP_CALC,
      OP_MUL,
      OP_CMP,
      OP_JUMP,
      OP_FIN,
      OP_TAT,
      OP_ACC,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      logic last_entry;    // scan index sits on the last loaded job
      logic have_best;     // scan has found an arrived job
      logic batch_done;    // every loaded job has been scheduled
   } dp_status_type;

endpackage

/* rtl/hrrn_req_if.sv */
interface hrrn_req_if;
   logic                        valid;
   logic                        ready;
   logic [hrrn_pkg::DATA_W-1:0] burst_time;
   logic [hrrn_pkg::DATA_W-1:0] arrival_time;
   logic                        last_item;

   modport source (output valid, burst_time, arrival_time, last_item, input ready);
   modport sink   (input valid, burst_time, arrival_time, last_item, output ready);
endinterface

/* rtl/hrrn_rsp_if.sv */
interface hrrn_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hrrn_pkg::JOB_W-1:0]   job_number;
   logic [hrrn_pkg::TIME_W-1:0]  waiting_time;
   logic [hrrn_pkg::TIME_W-1:0]  turnaround_time;
   logic [hrrn_pkg::TOTAL_W-1:0] total_waiting;
   logic [hrrn_pkg::TOTAL_W-1:0] total_turnaround;
   logic                         last_result;

   modport source (output valid, job_number, waiting_time, turnaround_time,
                   total_waiting, total_turnaround, last_result, input ready);
   modport sink   (input valid, job_number, waiting_time, turnaround_time,
                   total_waiting, total_turnaround, last_result, output ready);
endinterface

/* rtl/hrrn_ctrl.sv */
module hrrn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_item,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  hrrn_pkg::dp_status_type status,
   output hrrn_pkg::dp_op_type     op
);

   typedef enum logic [9:0] {
      ST_LOAD   = 10'b00_0000_0001,
      ST_INIT   = 10'b00_0000_0010,
      ST_READ   = 10'b00_0000_0100,
      ST_CALC   = 10'b00_0000_1000,
      ST_MUL    = 10'b00_0001_0000,
      ST_CMP    = 10'b00_0010_0000,
      ST_DECIDE = 10'b00_0100_0000,
      ST_TAT    = 10'b00_1000_0000,
      ST_ACC    = 10'b01_0000_0000,
      ST_OUT    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      op       = hrrn_pkg::OP_NONE;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               op = hrrn_pkg::OP_LOAD;
               if (req_last_item) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            op       = hrrn_pkg::OP_SCAN_INIT;
            state_in = ST_READ;
         end
         ST_READ: begin
            op       = hrrn_pkg::OP_READ;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            op       = hrrn_pkg::OP_CALC;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            op       = hrrn_pkg::OP_MUL;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            op       = hrrn_pkg::OP_CMP;
            state_in = status.last_entry ? ST_DECIDE : ST_READ;
         end
         ST_DECIDE: begin
            if (status.have_best) begin
               op       = hrrn_pkg::OP_FIN;
               state_in = ST_TAT;
            end else begin
               op       = hrrn_pkg::OP_JUMP;
               state_in = ST_INIT;
            end
         end
         ST_TAT: begin
            op       = hrrn_pkg::OP_TAT;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            op       = hrrn_pkg::OP_ACC;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (status.batch_done) begin
                  op       = hrrn_pkg::OP_CLEAR;
                  state_in = ST_LOAD;
               end else begin
                  op       = hrrn_pkg::OP_SCAN_INIT;
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/hrrn_dpath.sv */
module hrrn_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  hrrn_pkg::dp_op_type           op,
   input  logic [hrrn_pkg::DATA_W-1:0]   req_burst_time,
   input  logic [hrrn_pkg::DATA_W-1:0]   req_arrival_time,
   output logic [hrrn_pkg::JOB_W-1:0]    rsp_job_number,
   output logic [hrrn_pkg::TIME_W-1:0]   rsp_waiting_time,
   output logic [hrrn_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic [hrrn_pkg::TOTAL_W-1:0]  rsp_total_waiting,
   output logic [hrrn_pkg::TOTAL_W-1:0]  rsp_total_turnaround,
   output logic                          rsp_last_result,
   output hrrn_pkg::dp_status_type       status
);

   // job stores
   logic [hrrn_pkg::DATA_W-1:0] arr_mem   [hrrn_pkg::MAX_PROCS];
   logic [hrrn_pkg::DATA_W-1:0] burst_mem [hrrn_pkg::MAX_PROCS];

   // control state
   logic [hrrn_pkg::CNT_W-1:0]     loaded_ff,    loaded_in;
   logic [hrrn_pkg::CNT_W-1:0]     completed_ff, completed_in;
   logic [hrrn_pkg::IDX_W-1:0]     idx_ff,       idx_in;
   logic                           have_best_ff, have_best_in;
   logic [hrrn_pkg::TIME_W-1:0]    now_ff,       now_in;
   logic [hrrn_pkg::TOTAL_W-1:0]   tot_w_ff,     tot_w_in;
   logic [hrrn_pkg::TOTAL_W-1:0]   tot_t_ff,     tot_t_in;
   logic [hrrn_pkg::MAX_PROCS-1:0] done_ff,      done_in;

   // scan pipeline
   logic [hrrn_pkg::DATA_W-1:0] rd_arr_ff, rd_burst_ff;
   logic                        rd_done_ff;
   logic [hrrn_pkg::NUM_W-1:0]  cur_num_ff,  cur_num_in;
   logic                        cur_elig_ff, cur_elig_in;
   logic [hrrn_pkg::DATA_W-1:0] min_ff,      min_in;
   logic [hrrn_pkg::PROD_W-1:0] prod_l_ff,   prod_l_in;
   logic [hrrn_pkg::PROD_W-1:0] prod_r_ff,   prod_r_in;

   // current best candidate
   logic [hrrn_pkg::IDX_W-1:0]  best_idx_ff,   best_idx_in;
   logic [hrrn_pkg::DATA_W-1:0] best_arr_ff,   best_arr_in;
   logic [hrrn_pkg::DATA_W-1:0] best_burst_ff, best_burst_in;
   logic [hrrn_pkg::NUM_W-1:0]  best_num_ff,   best_num_in;

   // finish arithmetic
   logic [hrrn_pkg::TIME_W-1:0] tat_ff, tat_in;
   logic [hrrn_pkg::TIME_W-1:0] wt_ff,  wt_in;

   // result register
   logic [hrrn_pkg::JOB_W-1:0]   out_job_ff,   out_job_in;
   logic [hrrn_pkg::TIME_W-1:0]  out_wt_ff,    out_wt_in;
   logic [hrrn_pkg::TIME_W-1:0]  out_tat_ff,   out_tat_in;
   logic [hrrn_pkg::TOTAL_W-1:0] out_tot_w_ff, out_tot_w_in;
   logic [hrrn_pkg::TOTAL_W-1:0] out_tot_t_ff, out_tot_t_in;
   logic                         out_last_ff,  out_last_in;

   logic                        not_full;
   logic                        take;
   logic [hrrn_pkg::NUM_W-1:0]  fin_sum;
   logic [hrrn_pkg::TIME_W-1:0] tat_val;
   logic [hrrn_pkg::SUM_W-1:0]  sum_w, sum_t;

   assign not_full = (loaded_ff < hrrn_pkg::CNT_W'(hrrn_pkg::MAX_PROCS));

   // higher ratio wins; equal ratio goes to the earlier arrival, then lower index
   assign take = cur_elig_ff &&
                 (!have_best_ff || (prod_l_ff > prod_r_ff) ||
                  ((prod_l_ff == prod_r_ff) && (rd_arr_ff < best_arr_ff)));

   assign fin_sum = hrrn_pkg::NUM_W'(now_ff) + hrrn_pkg::NUM_W'(best_burst_ff);
   assign tat_val = now_ff - hrrn_pkg::TIME_W'(best_arr_ff);
   assign sum_w   = hrrn_pkg::SUM_W'(tot_w_ff) + hrrn_pkg::SUM_W'(wt_ff);
   assign sum_t   = hrrn_pkg::SUM_W'(tot_t_ff) + hrrn_pkg::SUM_W'(tat_ff);

   always_comb begin
      loaded_in     = loaded_ff;
      completed_in  = completed_ff;
      idx_in        = idx_ff;
      have_best_in  = have_best_ff;
      now_in        = now_ff;
      tot_w_in      = tot_w_ff;
      tot_t_in      = tot_t_ff;
      done_in       = done_ff;
      cur_num_in    = cur_num_ff;
      cur_elig_in   = cur_elig_ff;
      min_in        = min_ff;
      prod_l_in     = prod_l_ff;
      prod_r_in     = prod_r_ff;
      best_idx_in   = best_idx_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_num_in   = best_num_ff;
      tat_in        = tat_ff;
      wt_in         = wt_ff;
      out_job_in    = out_job_ff;
      out_wt_in     = out_wt_ff;
      out_tat_in    = out_tat_ff;
      out_tot_w_in  = out_tot_w_ff;
      out_tot_t_in  = out_tot_t_ff;
      out_last_in   = out_last_ff;

      unique case (op)
         hrrn_pkg::OP_LOAD: begin
            if (not_full) loaded_in = loaded_ff + hrrn_pkg::CNT_W'(1);
         end
         hrrn_pkg::OP_SCAN_INIT: begin
            idx_in       = '0;
            have_best_in = 1'b0;
            min_in       = '1;
         end
         hrrn_pkg::OP_CALC: begin
            cur_num_in  = hrrn_pkg::NUM_W'(now_ff) - hrrn_pkg::NUM_W'(rd_arr_ff)
                        + hrrn_pkg::NUM_W'(rd_burst_ff);
            cur_elig_in = !rd_done_ff && (hrrn_pkg::TIME_W'(rd_arr_ff) <= now_ff);
            if (!rd_done_ff && (rd_arr_ff < min_ff)) min_in = rd_arr_ff;
         end
         hrrn_pkg::OP_MUL: begin
            prod_l_in = hrrn_pkg::PROD_W'(cur_num_ff) * hrrn_pkg::PROD_W'(best_burst_ff);
            prod_r_in = hrrn_pkg::PROD_W'(best_num_ff) * hrrn_pkg::PROD_W'(rd_burst_ff);
         end
         hrrn_pkg::OP_CMP: begin
            if (take) begin
               best_idx_in   = idx_ff;
               best_arr_in   = rd_arr_ff;
               best_burst_in = rd_burst_ff;
               best_num_in   = cur_num_ff;
               have_best_in  = 1'b1;
            end
            idx_in = idx_ff + hrrn_pkg::IDX_W'(1);
         end
         hrrn_pkg::OP_JUMP: begin
            now_in = hrrn_pkg::TIME_W'(min_ff);
         end
         hrrn_pkg::OP_FIN: begin
            now_in = (fin_sum > hrrn_pkg::NUM_W'(hrrn_pkg::TIME_MAX)) ?
                     hrrn_pkg::TIME_MAX : fin_sum[hrrn_pkg::TIME_W-1:0];
         end
         hrrn_pkg::OP_TAT: begin
            tat_in = tat_val;
            wt_in  = (tat_val > hrrn_pkg::TIME_W'(best_burst_ff)) ?
                     tat_val - hrrn_pkg::TIME_W'(best_burst_ff) : '0;
         end
         hrrn_pkg::OP_ACC: begin
            tot_w_in = (sum_w > hrrn_pkg::SUM_W'(hrrn_pkg::TOTAL_MAX)) ?
                       hrrn_pkg::TOTAL_MAX : sum_w[hrrn_pkg::TOTAL_W-1:0];
            tot_t_in = (sum_t > hrrn_pkg::SUM_W'(hrrn_pkg::TOTAL_MAX)) ?
                       hrrn_pkg::TOTAL_MAX : sum_t[hrrn_pkg::TOTAL_W-1:0];
            out_job_in   = hrrn_pkg::JOB_W'(best_idx_ff) + hrrn_pkg::JOB_W'(1);
            out_wt_in    = wt_ff;
            out_tat_in   = tat_ff;
            out_tot_w_in = tot_w_in;
            out_tot_t_in = tot_t_in;
            out_last_in  = ((completed_ff + hrrn_pkg::CNT_W'(1)) == loaded_ff);
            completed_in = completed_ff + hrrn_pkg::CNT_W'(1);
            done_in[best_idx_ff] = 1'b1;
         end
         hrrn_pkg::OP_CLEAR: begin
            loaded_in    = '0;
            completed_in = '0;
            now_in       = '0;
            tot_w_in     = '0;
            tot_t_in     = '0;
            done_in      = '0;
         end
         default: ;
      endcase
   end

   // stores: written on load, read one entry per scan step
   always_ff @(posedge clock) begin
      if ((op == hrrn_pkg::OP_LOAD) && not_full) begin
         arr_mem[loaded_ff[hrrn_pkg::IDX_W-1:0]]   <= req_arrival_time;
         burst_mem[loaded_ff[hrrn_pkg::IDX_W-1:0]] <= req_burst_time;
      end
      if (op == hrrn_pkg::OP_READ) begin
         rd_arr_ff   <= arr_mem[idx_ff];
         rd_burst_ff <= burst_mem[idx_ff];
         rd_done_ff  <= done_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         completed_ff <= '0;
         idx_ff       <= '0;
         have_best_ff <= 1'b0;
         now_ff       <= '0;
         tot_w_ff     <= '0;
         tot_t_ff     <= '0;
         done_ff      <= '0;
      end else begin
         loaded_ff    <= loaded_in;
         completed_ff <= completed_in;
         idx_ff       <= idx_in;
         have_best_ff <= have_best_in;
         now_ff       <= now_in;
         tot_w_ff     <= tot_w_in;
         tot_t_ff     <= tot_t_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_num_ff    <= cur_num_in;
      cur_elig_ff   <= cur_elig_in;
      min_ff        <= min_in;
      prod_l_ff     <= prod_l_in;
      prod_r_ff     <= prod_r_in;
      best_idx_ff   <= best_idx_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_num_ff   <= best_num_in;
      tat_ff        <= tat_in;
      wt_ff         <= wt_in;
      out_job_ff    <= out_job_in;
      out_wt_ff     <= out_wt_in;
      out_tat_ff    <= out_tat_in;
      out_tot_w_ff  <= out_tot_w_in;
      out_tot_t_ff  <= out_tot_t_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_job_number       = out_job_ff;
   assign rsp_waiting_time     = out_wt_ff;
   assign rsp_turnaround_time  = out_tat_ff;
   assign rsp_total_waiting    = out_tot_w_ff;
   assign rsp_total_turnaround = out_tot_t_ff;
   assign rsp_last_result      = out_last_ff;

   assign status.last_entry = (hrrn_pkg::CNT_W'(idx_ff) == (loaded_ff - hrrn_pkg::CNT_W'(1)));
   assign status.have_best  = have_best_ff;
   assign status.batch_done = (completed_ff == loaded_ff);

endmodule

/* rtl/hrrn_batch_scheduler.sv */
// Load: one job transaction per cycle while idle; no result for a non-final job.
// Schedule: each pick scans all n loaded jobs by read, ratio, multiply and compare steps per
// job, then decides, finishes and accumulates before the result is registered. If no loaded
// job has arrived yet (as for a batch starting after tick zero), decide jumps the clock to
// the earliest pending arrival and scans again; the next pick waits for the previous result
// to be taken. Reset (synchronous, active high) empties the batch, clears done flags and
// counters; the job stores are not cleared and are only read once loaded.
module hrrn_batch_scheduler (
   input logic        clock,
   input logic        reset,
   hrrn_req_if.sink   req_ch,
   hrrn_rsp_if.source rsp_ch
);

   // controller / datapath handshake
   hrrn_pkg::dp_op_type     op;
   hrrn_pkg::dp_status_type status;

   // The controller sequences loading, the per-job scan and the result hand-off.
   // req ready only while loading; rsp valid holds in its own state until taken.
   hrrn_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_last_item (req_ch.last_item),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .status        (status),
      .op            (op)
   );

   // The datapath holds the job stores, the clock of the schedule, the best
   // candidate of the running scan and the registered result.
   // Ratios (wait+burst)/burst are compared by cross products, no division.
   hrrn_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .op                   (op),
      .req_burst_time       (req_ch.burst_time),
      .req_arrival_time     (req_ch.arrival_time),
      .rsp_job_number       (rsp_ch.job_number),
      .rsp_waiting_time     (rsp_ch.waiting_time),
      .rsp_turnaround_time  (rsp_ch.turnaround_time),
      .rsp_total_waiting    (rsp_ch.total_waiting),
      .rsp_total_turnaround (rsp_ch.total_turnaround),
      .rsp_last_result      (rsp_ch.last_result),
      .status               (status)
   );

endmodule
